// File: sv/efg_pkg.sv
// Package for the event flag group: payload types, command codes, defaults and the wait test.
package efg_pkg;

	localparam int FIELD_W        = 16;
	localparam int SLOT_W         = 4;
	localparam int TASK_SLOTS_DEF = 16;
	localparam int FLAG_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		CMD_SET   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_PEND  = 2'd2
	} efg_cmd_t;

	typedef struct packed {
		efg_cmd_t            cmd;
		logic [FIELD_W-1:0]  mask;
		logic [SLOT_W-1:0]   task_id;
		logic                wait_all;
		logic                in_isr;
	} efg_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] flags;
		logic [FIELD_W-1:0] released;
		logic               blocked;
		logic               reschedule;
	} efg_rsp_t;

	// Update request from the command logic to the waiter table
	typedef struct packed {
		logic              release_en;
		logic              pend_en;
		logic [SLOT_W-1:0] slot;
		logic              all_mode;
	} efg_tbl_ctl_t;

	// Any mode: some masked bit is set. All mode: every masked bit is set.
	function automatic logic cond_holds(logic [FIELD_W-1:0] flags, logic [FIELD_W-1:0] m,
			logic all_mode);
		logic [FIELD_W-1:0] hit;
		hit = flags & m;
		if (all_mode) begin
			return hit == m;
		end else begin
			return hit != '0;
		end
	endfunction

endpackage

// File: sv/event_flag_group.sv
// Top level of the event flag group: command register, flag word, waiter table, result register.
//
// Event flag group for a small real-time kernel. A command (set, clear or pend) is taken on
// the cmd channel and gives exactly one result on the rsp channel. Set ORs the mask into the
// flag word and releases, in the same step, every waiting slot whose any/all condition now
// holds; released carries one bit per slot (slots 0 to 15) and reschedule is raised when
// something was released outside interrupt context. Clear drops the masked flag bits. Pend
// either passes at once (blocked 0) or records the slot as a waiter (blocked 1); slots at or
// above TASK_SLOTS never block. Command code 3 changes nothing. A transfer on the cfg channel
// loads the flag word and empties the waiter table; issue it only while no command is in
// flight. Rate: one command per cycle while rsp_ready keeps the result register draining. A
// command passes the command register and then the result register; between the two lies the
// single pass through the waiter compare, where every entry is tested against the new flag word.
module event_flag_group #(
	parameter int TASK_SLOTS = efg_pkg::TASK_SLOTS_DEF,
	parameter int FLAG_BITS  = efg_pkg::FLAG_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  efg_pkg::efg_req_t             cmd_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output efg_pkg::efg_rsp_t             rsp_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [efg_pkg::FIELD_W-1:0]   cfg_data
);

	// Flag word never holds more bits than the fields carry
	localparam int FW = (FLAG_BITS < efg_pkg::FIELD_W) ? FLAG_BITS : efg_pkg::FIELD_W;

	efg_pkg::efg_req_t     cmd_s1;
	logic                  v_s1;
	efg_pkg::efg_rsp_t     rsp_s2;
	logic                  v_s2;
	logic [FW-1:0]         flags_q;

	logic [FW-1:0]         m;
	logic [FW-1:0]         flags_nx;
	logic                  set_op;
	logic                  pend_blk;
	logic                  slot_ok;
	logic                  adv;
	logic                  cfg_wr;
	efg_pkg::efg_tbl_ctl_t tbl_ctl;
	logic [TASK_SLOTS-1:0] hits;
	logic [TASK_SLOTS-1:0] wait_valid;
	logic [efg_pkg::FIELD_W-1:0] rel_vec;

	// Advance the command stage when the result register is free or being drained
	assign adv       = v_s1 && (!v_s2 || rsp_ready);
	assign cmd_ready = !v_s1 || adv;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_valid && cmd_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd_data;
		end
	end

	// Command decode and next flag word
	assign m       = cmd_s1.mask[FW-1:0];
	assign slot_ok = 32'(cmd_s1.task_id) < TASK_SLOTS;

	always_comb begin
		flags_nx = flags_q;
		set_op   = 1'b0;
		pend_blk = 1'b0;
		case (cmd_s1.cmd)
			efg_pkg::CMD_SET: begin
				flags_nx = flags_q | m;
				set_op   = 1'b1;
			end
			efg_pkg::CMD_CLEAR: begin
				flags_nx = flags_q & ~m;
			end
			efg_pkg::CMD_PEND: begin
				pend_blk = slot_ok && !efg_pkg::cond_holds(efg_pkg::FIELD_W'(flags_q),
					efg_pkg::FIELD_W'(m), cmd_s1.wait_all);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		tbl_ctl            = '0;
		tbl_ctl.release_en = adv && set_op;
		tbl_ctl.pend_en    = adv && pend_blk;
		tbl_ctl.slot       = cmd_s1.task_id;
		tbl_ctl.all_mode   = cmd_s1.wait_all;
	end

	efg_waiter_table #(
		.TASK_SLOTS (TASK_SLOTS),
		.FW         (FW)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_wr),
		.ctl        (tbl_ctl),
		.pend_mask  (m),
		.probe      (flags_nx),
		.hits       (hits),
		.wait_valid (wait_valid)
	);

	// Report slots 0 to 15 only; slots beyond the table read as zero
	for (genvar j = 0; j < efg_pkg::FIELD_W; j++) begin : g_rel
		if (j < TASK_SLOTS) begin : g_on
			assign rel_vec[j] = set_op && hits[j];
		end else begin : g_off
			assign rel_vec[j] = 1'b0;
		end
	end

	// Flag word: a configuration transfer wins, otherwise take the command's result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cfg_wr) begin
			flags_q <= cfg_data[FW-1:0];
		end else if (adv) begin
			flags_q <= flags_nx;
		end
	end

	// Result register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (rsp_ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2.flags      <= efg_pkg::FIELD_W'(flags_nx);
			rsp_s2.released   <= rel_vec;
			rsp_s2.blocked    <= pend_blk;
			rsp_s2.reschedule <= (rel_vec != '0) && !cmd_s1.in_isr;
		end
	end

	assign rsp_valid = v_s2;
	assign rsp_data  = rsp_s2;

	// A reschedule request always comes with at least one released slot
	a_resched_has_release: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rsp_s2.reschedule |-> rsp_s2.released != '0)
		else $error("reschedule without released slot");

	// A pend never releases anything, and a set never blocks
	a_block_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rsp_s2.blocked |-> rsp_s2.released == '0)
		else $error("blocked result carries released slots");

	// Every waiter released by a set is gone from the table afterwards
	a_release_drops: assert property (@(posedge clk) disable iff (!arst_n)
		adv && set_op && !cfg_wr |=> ($past(hits) & wait_valid) == '0)
		else $error("released waiter still valid");

	// A blocking pend leaves at least one waiter in the table
	a_pend_records: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pend_blk && !cfg_wr |=> wait_valid != '0)
		else $error("blocking pend not recorded");

endmodule

// File: sv/efg_waiter_table.sv
// Waiter table: one entry per task slot, all entries tested against the flag word in parallel.
module efg_waiter_table #(
	parameter int TASK_SLOTS = efg_pkg::TASK_SLOTS_DEF,
	parameter int FW         = efg_pkg::FLAG_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clear,
	input  efg_pkg::efg_tbl_ctl_t  ctl,
	input  logic [FW-1:0]          pend_mask,
	input  logic [FW-1:0]          probe,
	output logic [TASK_SLOTS-1:0]  hits,
	output logic [TASK_SLOTS-1:0]  wait_valid
);

	logic [TASK_SLOTS-1:0] valid_q;
	logic [TASK_SLOTS-1:0] all_q;
	logic [FW-1:0]         mask_q [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] wr_sel;

	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			wr_sel[i] = ctl.pend_en && (32'(ctl.slot) == i);
			hits[i]   = valid_q[i] && efg_pkg::cond_holds(efg_pkg::FIELD_W'(probe),
				efg_pkg::FIELD_W'(mask_q[i]), all_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			all_q   <= '0;
		end else if (clear) begin
			valid_q <= '0;
			all_q   <= '0;
		end else begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				if (wr_sel[i]) begin
					valid_q[i] <= 1'b1;
					all_q[i]   <= ctl.all_mode;
				end else if (ctl.release_en && hits[i]) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// Masks are only read behind a valid bit
	always_ff @(posedge clk) begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (wr_sel[i]) begin
				mask_q[i] <= pend_mask;
			end
		end
	end

	assign wait_valid = valid_q;

endmodule

// File: bench/efg_result_check.sv
// Result checker for the event flag group: tracks flags and waiters, compares every result.
`timescale 1ns / 1ps

module efg_result_check
	import efg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_ready,
	input  efg_req_t           cmd_data,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  efg_rsp_t           rsp_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [FIELD_W-1:0] cfg_data,
	output int                 fail_count,
	output int                 pending
);

	logic [FIELD_W-1:0] flag_word;
	logic [15:0]        waiting;
	logic [15:0]        all_mode;
	logic [FIELD_W-1:0] wait_mask [16];
	efg_rsp_t           expected_q [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic wait_met(input logic [FIELD_W-1:0] f, input logic [FIELD_W-1:0] m,
			input logic all);
		if (all) begin
			return (m & ~f) == '0;
		end
		return |(f & m);
	endfunction

	// Apply one command to the tracked state and return the result it should give.
	task automatic run_command(input efg_req_t r, output efg_rsp_t e);
		e = '0;
		case (r.cmd)
			CMD_SET: begin
				flag_word = flag_word | r.mask;
				for (int s = 0; s < 16; s++) begin
					if (waiting[s] && wait_met(flag_word, wait_mask[s], all_mode[s])) begin
						waiting[s] = 1'b0;
						e.released[s] = 1'b1;
					end
				end
				e.reschedule = (e.released != '0) && !r.in_isr;
			end
			CMD_CLEAR: begin
				flag_word = flag_word & ~r.mask;
			end
			CMD_PEND: begin
				if (!wait_met(flag_word, r.mask, r.wait_all)) begin
					waiting[r.task_id] = 1'b1;
					all_mode[r.task_id] = r.wait_all;
					wait_mask[r.task_id] = r.mask;
					e.blocked = 1'b1;
				end
			end
			default: ;
		endcase
		e.flags = flag_word;
	endtask

	task automatic note_failure(input string what, input efg_rsp_t e);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t efg %s: flags %h/%h released %h/%h blocked %b/%b resched %b/%b",
				$realtime, what, e.flags, rsp_data.flags, e.released, rsp_data.released,
				e.blocked, rsp_data.blocked, e.reschedule, rsp_data.reschedule);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		efg_rsp_t e;
		if (!arst_n) begin
			flag_word = '0;
			waiting = '0;
			all_mode = '0;
			expected_q.delete();
		end else begin
			// compare first: a result never belongs to a command taken on the same edge
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					note_failure("unexpected result (exp/got)", '0);
				end else begin
					e = expected_q.pop_front();
					if (rsp_data.flags !== e.flags || rsp_data.released !== e.released ||
							rsp_data.blocked !== e.blocked ||
							rsp_data.reschedule !== e.reschedule) begin
						note_failure("mismatch (exp/got)", e);
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				run_command(cmd_data, e);
				expected_q.push_back(e);
			end
			if (cfg_valid && cfg_ready) begin
				flag_word = cfg_data;
				waiting = '0;
				all_mode = '0;
			end
		end
		pending = expected_q.size();
	end

endmodule

// File: bench/tb.sv
// Testbench top for the event flag group: clock, reset, command and config stimulus, verdict.
`timescale 1ns / 1ps

module tb;
	import efg_pkg::*;

	// Command code the block must treat as a no-op
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         PHASES     = 8;
	localparam int         PHASE_ITEMS = 135;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_ready;
	efg_req_t           cmd_data;
	logic               rsp_valid;
	logic               rsp_ready;
	efg_rsp_t           rsp_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [FIELD_W-1:0] cfg_data;
	int                 fails;
	int                 pending;

	// When set, both sides run without idle cycles
	bit                 quiet;

	event_flag_group u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	efg_result_check u_result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_data   (cmd_data),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_data   (rsp_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fails),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Draw the idle cycles in front of one transfer; none while quiet is set.
	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic efg_req_t make_req(input logic [1:0] c, input logic [FIELD_W-1:0] m,
			input logic [SLOT_W-1:0] id, input logic all, input logic isr);
		efg_req_t r;
		r.cmd = efg_cmd_t'(c);
		r.mask = m;
		r.task_id = id;
		r.wait_all = all;
		r.in_isr = isr;
		return r;
	endfunction

	// Mostly sparse masks, so that waiters build up and get released a few at a time.
	function automatic logic [FIELD_W-1:0] event_mask();
		logic [FIELD_W-1:0] m;
		m = '0;
		case ($urandom_range(0, 9))
			0: m = '0;
			1: m = '1;
			2, 3: m = FIELD_W'($urandom);
			default: begin
				repeat ($urandom_range(1, 3)) m[$urandom_range(0, FIELD_W - 1)] = 1'b1;
			end
		endcase
		return m;
	endfunction

	function automatic efg_req_t random_req();
		int          pick;
		logic [1:0]  c;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			c = CMD_PEND;
		end else if (pick < 66) begin
			c = CMD_SET;
		end else if (pick < 95) begin
			c = CMD_CLEAR;
		end else begin
			c = CMD_UNUSED;
		end
		return make_req(c, event_mask(), SLOT_W'($urandom_range(0, 15)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	// Enter and leave at a falling edge. Drop valid only when an idle gap follows,
	// so back-to-back commands keep valid high and just swap the payload.
	task automatic send_cmd(input efg_req_t r);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			cmd_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_data = r;
		cmd_valid = 1'b1;
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
	endtask

	// Load the flag word only once every result is back and the block has settled.
	task automatic load_flags(input logic [FIELD_W-1:0] v);
		cmd_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side: hold ready low for a drawn number of cycles, then wait for one transfer.
	initial begin
		int gap;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				rsp_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready = 1'b1;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	// Stop a hung run; far above the slowest correct run.
	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		logic [FIELD_W-1:0] setting [PHASES];
		arst_n = 1'b0;
		quiet = 1'b0;
		cmd_valid = 1'b0;
		cmd_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		setting = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 16'h5A5A, 16'h0000,
			16'hFFFF};
		setting[5] = FIELD_W'($urandom);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, from the reset flag word of zero.
		send_cmd(make_req(CMD_PEND, 16'h0001, 4'd0, 1'b0, 1'b0));   // any mode, blocks
		send_cmd(make_req(CMD_PEND, 16'h0003, 4'd1, 1'b1, 1'b0));   // all mode, blocks
		send_cmd(make_req(CMD_PEND, 16'h0000, 4'd2, 1'b0, 1'b0));   // empty any mask never wakes
		send_cmd(make_req(CMD_PEND, 16'h0000, 4'd3, 1'b1, 1'b1));   // empty all mask passes
		send_cmd(make_req(CMD_PEND, 16'hFFFF, 4'd15, 1'b1, 1'b0));  // top slot, every bit
		send_cmd(make_req(CMD_SET, 16'h0001, 4'd0, 1'b0, 1'b1));    // release from interrupt
		send_cmd(make_req(CMD_SET, 16'h0002, 4'd7, 1'b1, 1'b0));    // release with reschedule
		send_cmd(make_req(CMD_PEND, 16'h0002, 4'd4, 1'b0, 1'b0));   // already satisfied
		send_cmd(make_req(CMD_PEND, 16'h8000, 4'd5, 1'b0, 1'b0));
		send_cmd(make_req(CMD_PEND, 16'h0100, 4'd5, 1'b1, 1'b1));   // overwrite waiting slot
		send_cmd(make_req(CMD_SET, 16'h8000, 4'd0, 1'b0, 1'b0));    // old mask must not wake it
		send_cmd(make_req(CMD_SET, 16'h0100, 4'd0, 1'b0, 1'b0));
		send_cmd(make_req(CMD_CLEAR, 16'hFFFF, 4'd9, 1'b1, 1'b1));
		send_cmd(make_req(CMD_UNUSED, 16'hFFFF, 4'd15, 1'b1, 1'b1));
		send_cmd(make_req(CMD_PEND, 16'hAAAA, 4'd6, 1'b0, 1'b1));
		send_cmd(make_req(CMD_PEND, 16'h5555, 4'd8, 1'b1, 1'b0));
		send_cmd(make_req(CMD_SET, 16'hFFFF, 4'd0, 1'b0, 1'b0));    // wake all but empty mask
		send_cmd(make_req(CMD_UNUSED, 16'h0000, 4'd0, 1'b0, 1'b0));
		send_cmd(make_req(CMD_CLEAR, 16'h00F0, 4'd0, 1'b0, 1'b0));
		send_cmd(make_req(CMD_SET, 16'h0000, 4'd0, 1'b0, 1'b0));    // slot 2 stays asleep

		// Random phases, each starting from a fresh flag word and an emptied table.
		for (int p = 0; p < PHASES; p++) begin
			load_flags(setting[p]);
			quiet = (p % 3 == 1);
			repeat (PHASE_ITEMS) send_cmd(random_req());
		end

		cmd_valid = 1'b0;
		quiet = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fails == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
